// ===== src/assert_macros.svh =====
// Assertion macros shared by the sine block sources.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/dst_pkg.sv =====
// Package for the degree sine block: widths, constants and per-term tables.
// Used by dst_angle, dst_mul and degree_sine_taylor; depends on nothing.
package dst_pkg;

  localparam int ANG_W     = 16;
  localparam int TC_W      = 4;
  localparam int OUT_W     = 32;
  localparam int DEG_W     = 7;
  localparam int RED_W     = 17;
  localparam int DIV_W     = 9;
  localparam int OPD_W     = 32;
  localparam int PROD_W    = 64;
  localparam int IN_DATA_W = 24;

  localparam int MAX_TERMS = 10;
  localparam int FRAC_BITS = 30;

  localparam int ANG_MOD   = 360;
  localparam int DEG_HALF  = 180;
  localparam int DEG_QUART = 90;
  localparam int RED_OFS   = ANG_MOD * 92;
  localparam int RED_STEPS = 8;

  localparam longint unsigned PI_NUM = 64'd314159;
  localparam longint unsigned PI_DEN = 64'd18000000;

  localparam longint unsigned TWO_32 = 64'd1 << 32;

  localparam logic [DIV_W-1:0] TERM_DIV [0:15] = '{
    9'd1, 9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210,
    9'd272, 9'd342, 9'd1, 9'd1, 9'd1, 9'd1, 9'd1, 9'd1
  };

  localparam logic [OPD_W-1:0] TERM_RECIP [0:15] = '{
    32'd0,
    32'(TWO_32 / 64'd6),
    32'(TWO_32 / 64'd20),
    32'(TWO_32 / 64'd42),
    32'(TWO_32 / 64'd72),
    32'(TWO_32 / 64'd110),
    32'(TWO_32 / 64'd156),
    32'(TWO_32 / 64'd210),
    32'(TWO_32 / 64'd272),
    32'(TWO_32 / 64'd342),
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

  typedef struct packed {
    logic             done;
    logic             neg;
    logic [DEG_W-1:0] deg;
  } ang_res_t;

endpackage

// ===== src/degree_sine_taylor.sv =====
// A request is taken only in S_IDLE; the next one waits until the angle reduction, the Taylor
// terms after the first on the shared multiplier and the hand-over of the result to the output
// register are through. The term count N is clamped to 1..MAX_TERMS.
// The finished result waits in an output register while the next request is taken.
// Reset (rst, synchronous, active high) clears the sequencer and the output valid flag.
`include "assert_macros.svh"

module degree_sine_taylor #(
  parameter int MAX_TERMS = dst_pkg::MAX_TERMS,
  parameter int FRAC_BITS = dst_pkg::FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [15:0] angle_degrees, [19:16] term_count, [23:20] zero
  input  logic [dst_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] sine_value
  output logic [dst_pkg::OUT_W-1:0]         m_axis_tdata
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RED  = 4'd1;
  localparam logic [3:0] S_XLD  = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_SQR  = 4'd4;
  localparam logic [3:0] S_M1   = 4'd5;
  localparam logic [3:0] S_M1R  = 4'd6;
  localparam logic [3:0] S_M2   = 4'd7;
  localparam logic [3:0] S_M3   = 4'd8;
  localparam logic [3:0] S_M3R  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  localparam int F = FRAC_BITS;
  localparam logic [dst_pkg::PROD_W-1:0] HALF_ONE = 64'd1 << (F - 1);

  logic [3:0]                          state;
  logic                                req_acc;
  logic [dst_pkg::TC_W-1:0]            tc_in;
  logic [dst_pkg::TC_W-1:0]            terms;
  logic [dst_pkg::TC_W-1:0]            idx;
  dst_pkg::ang_res_t                   ang;
  logic [dst_pkg::OPD_W-1:0]           xtab [0:dst_pkg::DEG_QUART];
  logic [dst_pkg::OPD_W-1:0]           x;
  logic [dst_pkg::OPD_W-1:0]           x2;
  logic [dst_pkg::OPD_W-1:0]           t;
  logic [dst_pkg::OPD_W-1:0]           m;
  logic [dst_pkg::OPD_W-1:0]           q0;
  logic signed [dst_pkg::OUT_W-1:0]    sum;
  logic                                neg;
  logic                                mul_en;
  logic [dst_pkg::OPD_W-1:0]           mul_a;
  logic [dst_pkg::OPD_W-1:0]           mul_b;
  logic [dst_pkg::PROD_W-1:0]          prod;
  logic [dst_pkg::DIV_W-1:0]           k;
  logic [dst_pkg::OPD_W:0]             rem;
  logic [dst_pkg::OPD_W-1:0]           tnew;

  for (genvar g = 0; g <= dst_pkg::DEG_QUART; g++) begin : g_xtab
    localparam longint unsigned XNum = 64'(g) * dst_pkg::PI_NUM * (64'd1 << F) +
                                       dst_pkg::PI_DEN / 64'd2;
    localparam longint unsigned XVal = XNum / dst_pkg::PI_DEN;
    assign xtab[g] = 32'(XVal);
  end

  assign req_acc       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign tc_in         = s_axis_tdata[19:16];
  assign k             = dst_pkg::TERM_DIV[idx];

  always_comb begin
    rem  = {1'b0, m} - prod[dst_pkg::OPD_W:0];
    tnew = (rem >= 33'(k)) ? (q0 + 32'd1) : q0;
  end

  always_comb begin
    mul_en = 1'b1;
    mul_a  = x;
    mul_b  = x;
    unique case (state)
      S_SQ: begin
        mul_a = x;
        mul_b = x;
      end
      S_M1: begin
        mul_a = t;
        mul_b = x2;
      end
      S_M2: begin
        mul_a = m;
        mul_b = dst_pkg::TERM_RECIP[idx];
      end
      S_M3: begin
        mul_a = prod[dst_pkg::PROD_W-1:dst_pkg::OPD_W];
        mul_b = 32'(k);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  dst_angle u_angle (
    .clk   (clk),
    .rst   (rst),
    .start (req_acc),
    .angle (s_axis_tdata[dst_pkg::ANG_W-1:0]),
    .res   (ang)
  );

  dst_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            if (tc_in == 4'd0) begin
              terms <= 4'd1;
            end else if (tc_in > 4'(MAX_TERMS)) begin
              terms <= 4'(MAX_TERMS);
            end else begin
              terms <= tc_in;
            end
            state <= S_RED;
          end
        end
        S_RED: begin
          if (ang.done) begin
            state <= S_XLD;
          end
        end
        S_XLD: begin
          x     <= xtab[ang.deg];
          t     <= xtab[ang.deg];
          sum   <= $signed(xtab[ang.deg]);
          neg   <= ang.neg;
          idx   <= 4'd1;
          state <= S_SQ;
        end
        S_SQ: begin
          state <= S_SQR;
        end
        S_SQR: begin
          x2    <= 32'((prod + HALF_ONE) >> F);
          state <= (terms == 4'd1) ? S_DONE : S_M1;
        end
        S_M1: begin
          state <= S_M1R;
        end
        S_M1R: begin
          m     <= 32'((prod + (64'(k) << (F - 1))) >> F);
          state <= S_M2;
        end
        S_M2: begin
          state <= S_M3;
        end
        S_M3: begin
          q0    <= prod[dst_pkg::PROD_W-1:dst_pkg::OPD_W];
          state <= S_M3R;
        end
        S_M3R: begin
          t <= tnew;
          if (idx[0]) begin
            sum <= sum - $signed(tnew);
          end else begin
            sum <= sum + $signed(tnew);
          end
          if (idx + 4'd1 == terms) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + 4'd1;
            state <= S_M1;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= neg ? 32'(-sum) : 32'(sum);
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NXT(a_start_red, clk, rst, req_acc, state == S_RED)
  `ASSERT_IMP(a_ang_done, clk, rst, ang.done, state == S_RED)
  `ASSERT_IMP(a_idx_range, clk, rst, state == S_M1, (idx < terms) && (idx != 4'd0))
  `ASSERT_IMP(a_rem_range, clk, rst, state == S_M3R, rem < 33'({k, 1'b0}))

endmodule

// ===== src/dst_angle.sv =====
// Angle reduction for the degree sine block: modulo 360 by compare and subtract,
// then the fold into 0..90 degrees with a sign. Depends on dst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dst_angle (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [dst_pkg::ANG_W-1:0]  angle,
  output dst_pkg::ang_res_t                 res
);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_RED  = 2'd1;
  localparam logic [1:0] P_FOLD = 2'd2;

  logic [1:0]                  phase;
  logic [2:0]                  step;
  logic [dst_pkg::RED_W-1:0]   u;
  logic [dst_pkg::RED_W-1:0]   sub;
  logic                        ge;
  logic [8:0]                  r9;
  logic [8:0]                  d1;
  logic [8:0]                  d2;
  logic                        neg1;

  always_comb begin
    sub  = dst_pkg::RED_W'(dst_pkg::ANG_MOD) << step;
    ge   = (u >= sub);
    r9   = u[8:0];
    neg1 = (r9 > 9'(dst_pkg::DEG_HALF));
    d1   = neg1 ? (9'(dst_pkg::ANG_MOD) - r9) : r9;
    d2   = (d1 > 9'(dst_pkg::DEG_QUART)) ? (9'(dst_pkg::DEG_HALF) - d1) : d1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= P_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (start) begin
            u     <= {angle[dst_pkg::ANG_W-1], angle} + dst_pkg::RED_W'(dst_pkg::RED_OFS);
            step  <= 3'(dst_pkg::RED_STEPS - 1);
            phase <= P_RED;
          end
        end
        P_RED: begin
          if (ge) begin
            u <= u - sub;
          end
          if (step == 3'd0) begin
            phase <= P_FOLD;
          end else begin
            step <= step - 3'd1;
          end
        end
        P_FOLD: begin
          res.deg  <= d2[dst_pkg::DEG_W-1:0];
          res.neg  <= neg1;
          res.done <= 1'b1;
          phase    <= P_IDLE;
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMP(a_fold_range, clk, rst, res.done, res.deg <= 7'(dst_pkg::DEG_QUART))
  `ASSERT_IMP(a_red_bound, clk, rst, phase == P_FOLD, u < 17'(dst_pkg::ANG_MOD))

endmodule

// ===== src/dst_mul.sv =====
// Shared unsigned 32 x 32 multiplier of the degree sine block with a registered product.
// Depends on dst_pkg.
module dst_mul (
  input  logic                          clk,
  input  logic                          en,
  input  logic [dst_pkg::OPD_W-1:0]     a,
  input  logic [dst_pkg::OPD_W-1:0]     b,
  output logic [dst_pkg::PROD_W-1:0]    prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= {{(dst_pkg::PROD_W-dst_pkg::OPD_W){1'b0}}, a} *
              {{(dst_pkg::PROD_W-dst_pkg::OPD_W){1'b0}}, b};
    end
  end

endmodule
